// File: rtl/core/afs_pkg.sv
// Shared types and constants for the autofocus search controller.
// Used by the register block, the shared divider and the top level.
package afs_pkg;

    localparam int DIV_W = 33;
    localparam int DSR_W = 16;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_FRAME  = 2'd1;
    localparam logic [1:0] OP_STOP   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] MODE_ENDED    = 2'd0;
    localparam logic [1:0] MODE_SWEEP    = 2'd1;
    localparam logic [1:0] MODE_REVERSED = 2'd2;
    localparam logic [1:0] MODE_BRACKET  = 2'd3;

    localparam logic [2:0] REG_FOCUS_MIN    = 3'd0;
    localparam logic [2:0] REG_FOCUS_MAX    = 3'd1;
    localparam logic [2:0] REG_MAX_WAIT     = 3'd2;
    localparam logic [2:0] REG_MIN_WAIT     = 3'd3;
    localparam logic [2:0] REG_STEP_DIVISOR = 3'd4;
    localparam logic [2:0] REG_SWEEP        = 3'd5;

    localparam logic [19:0] SWEEP_THRESHOLD  = 20'd300;
    localparam logic [15:0] SWEEP_PARTS      = 16'd20;
    localparam logic [15:0] DEFAULT_MIN_WAIT = 16'd300;
    localparam logic [9:0]  US_PER_MS        = 10'd1000;
    localparam logic signed [2:0] HOLDOFF_FRAMES = 3'sd3;
    localparam logic signed [17:0] END_WIDTH     = 18'sd2;
    localparam logic [3:0]  RESTART_STEP_A   = 4'd4;
    localparam logic [3:0]  RESTART_STEP_B   = 4'd8;
    localparam logic [16:0] POS_TOP          = 17'd65535;
    localparam logic [16:0] FOCUS_LIMIT      = 17'd65536;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] time_us;
        logic [15:0] focus_position;
        logic [19:0] sharpness;
        logic        region_moved;
        logic        format_changed;
    } afs_in_t;

    typedef struct packed {
        logic        move;
        logic [16:0] target_focus;
        logic [1:0]  search_mode;
    } afs_out_t;

    typedef struct packed {
        logic [15:0] focus_min;
        logic [15:0] focus_max;
        logic [15:0] max_wait_ms;
        logic [15:0] min_wait_ms;
        logic [7:0]  step_divisor;
        logic        sweep_suggested;
    } afs_cfg_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } afs_div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } afs_div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_STRIDE,
        ST_ANALYZE,
        ST_NF,
        ST_NF_WAIT,
        ST_TMUL,
        ST_TDIV,
        ST_TMS,
        ST_TADD,
        ST_DONE
    } afs_state_t;

endpackage

// File: rtl/core/afs_regs.sv
// Configuration registers of the autofocus search controller behind an APB-style port.
// Depends on afs_pkg for the register indexes and the configuration struct.
module afs_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output afs_pkg::afs_cfg_t cfg
);

    afs_pkg::afs_cfg_t cfg_reg, cfg_next;
    logic              wr_en;
    logic [2:0]        idx;

    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                afs_pkg::REG_FOCUS_MIN:    cfg_next.focus_min = pwdata[15:0];
                afs_pkg::REG_FOCUS_MAX:    cfg_next.focus_max = pwdata[15:0];
                afs_pkg::REG_MAX_WAIT:     cfg_next.max_wait_ms = pwdata[15:0];
                afs_pkg::REG_MIN_WAIT:     cfg_next.min_wait_ms = pwdata[15:0];
                afs_pkg::REG_STEP_DIVISOR: cfg_next.step_divisor = pwdata[7:0];
                afs_pkg::REG_SWEEP:        cfg_next.sweep_suggested = pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            afs_pkg::REG_FOCUS_MIN:    prdata = {16'd0, cfg_reg.focus_min};
            afs_pkg::REG_FOCUS_MAX:    prdata = {16'd0, cfg_reg.focus_max};
            afs_pkg::REG_MAX_WAIT:     prdata = {16'd0, cfg_reg.max_wait_ms};
            afs_pkg::REG_MIN_WAIT:     prdata = {16'd0, cfg_reg.min_wait_ms};
            afs_pkg::REG_STEP_DIVISOR: prdata = {24'd0, cfg_reg.step_divisor};
            afs_pkg::REG_SWEEP:        prdata = {31'd0, cfg_reg.sweep_suggested};
            default:                   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.focus_min       <= 16'd0;
            cfg_reg.focus_max       <= 16'd0;
            cfg_reg.max_wait_ms     <= 16'd1000;
            cfg_reg.min_wait_ms     <= 16'd300;
            cfg_reg.step_divisor    <= 8'd1;
            cfg_reg.sweep_suggested <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/core/afs_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on afs_pkg for the request and response structs.
module afs_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  afs_pkg::afs_div_req_t req,
    output afs_pkg::afs_div_rsp_t rsp
);

    localparam int CNT_W = $clog2(afs_pkg::DIV_W + 1);

    logic [afs_pkg::DIV_W-1:0] quo_reg, quo_next;
    logic [afs_pkg::DSR_W-1:0] rem_reg, rem_next;
    logic [afs_pkg::DSR_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [afs_pkg::DSR_W:0]   trial;
    logic                      ge;

    assign trial = {rem_reg, quo_reg[afs_pkg::DIV_W-1]};
    assign ge    = trial >= {1'b0, dsr_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = CNT_W'(afs_pkg::DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? afs_pkg::DSR_W'(trial - {1'b0, dsr_reg})
                          : trial[afs_pkg::DSR_W-1:0];
            quo_next = {quo_reg[afs_pkg::DIV_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// File: rtl/core/autofocus_search_controller.sv
// Top level of the autofocus search controller: sequencer, search state and output register.
// Depends on afs_pkg, afs_regs and afs_div.
// The work for an item ranges from a stop, or a frame still in holdoff, up to a start with a sweep,
// set by up to three divider passes; its result beat appears as s_ready returns high.
// One item is worked on at a time; s_ready is high only while the sequencer is idle.
// Active-low sync reset sets search state and registers to defaults; item and result data stay.
module autofocus_search_controller (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  afs_pkg::afs_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output afs_pkg::afs_out_t m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    afs_pkg::afs_cfg_t     cfg;
    afs_pkg::afs_div_req_t div_req;
    afs_pkg::afs_div_rsp_t div_rsp;

    afs_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    afs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    afs_pkg::afs_state_t state_reg, state_next;
    afs_pkg::afs_in_t    item_reg, item_next;
    afs_pkg::afs_out_t   mdata_reg, mdata_next;
    logic                mvalid_reg, mvalid_next;

    logic [1:0]          mode_reg, mode_next;
    logic [16:0]         blo_reg, blo_next;
    logic [16:0]         bhi_reg, bhi_next;
    logic [16:0]         bpos_reg, bpos_next;
    logic [19:0]         bsharp_reg, bsharp_next;
    logic [15:0]         lens_reg, lens_next;
    logic signed [16:0]  stride_reg, stride_next;
    logic [3:0]          frames_reg, frames_next;
    logic signed [2:0]   hold_reg, hold_next;
    logic [63:0]         deadline_reg, deadline_next;
    logic                mv_reg, mv_next;
    logic [16:0]         nf_reg, nf_next;
    logic                dlgt_reg, dlgt_next;
    logic [32:0]         ms_reg, ms_next;
    logic [42:0]         scaled_reg, scaled_next;

    logic               accept;
    logic               out_free;
    logic               sq_hi;
    logic               start_sweep;
    logic signed [16:0] range_w;
    logic [15:0]        range_mag;
    logic signed [2:0]  hold_dec;
    logic               frame_go;
    logic [3:0]         frames_inc;
    logic               restart_hit;
    logic signed [17:0] lens_s, stride_s, blo_s, bhi_s, bpos_s;
    logic signed [17:0] v0, v1, v2, brk_raw;
    logic [16:0]        brk_val, v_clamped;
    logic               end_hit;
    logic               worse, lens_lt;
    logic [16:0]        m3_blo, m3_bhi;
    logic signed [17:0] m3_width;
    logic               m3_go;
    logic [16:0]        dl, dr;
    logic [7:0]         divisor_eff;
    logic [16:0]        step;
    logic signed [18:0] nf_down, nf_up;
    logic [16:0]        nf_calc;
    logic signed [17:0] tdiff_s;
    logic [16:0]        tdiff;
    logic               use_div;
    logic [15:0]        minw;
    logic [32:0]        ms_clamped;
    logic signed [16:0] stride_q;
    logic signed [17:0] left_gap, right_gap;

    assign accept   = s_valid && s_ready;
    assign out_free = !mvalid_reg || m_ready;
    assign s_ready  = (state_reg == afs_pkg::ST_IDLE);
    assign m_valid  = mvalid_reg;
    assign m_data   = mdata_reg;

    // Start decisions.
    assign sq_hi       = item_reg.sharpness > afs_pkg::SWEEP_THRESHOLD;
    assign start_sweep = cfg.sweep_suggested && !sq_hi;
    assign range_w     = $signed({1'b0, cfg.focus_max}) - $signed({1'b0, cfg.focus_min});
    assign range_mag   = range_w[16] ? 16'(-range_w) : range_w[15:0];
    assign stride_q    = range_w[16] ? -$signed({1'b0, div_rsp.quotient[15:0]})
                                     : $signed({1'b0, div_rsp.quotient[15:0]});
    assign left_gap    = $signed({2'b0, item_reg.focus_position}) - blo_s;
    assign right_gap   = bhi_s - $signed({2'b0, item_reg.focus_position});

    // Frame gating.
    assign hold_dec = (hold_reg > -3'sd1) ? hold_reg - 3'sd1 : hold_reg;
    assign frame_go = (mode_reg != afs_pkg::MODE_ENDED) && hold_dec[2]
                      && (item_reg.time_us > deadline_reg);

    // Analysis of a frame.
    assign frames_inc  = (frames_reg == 4'd15) ? frames_reg : frames_reg + 4'd1;
    assign restart_hit = ((frames_inc == afs_pkg::RESTART_STEP_A)
                          || (frames_inc == afs_pkg::RESTART_STEP_B)) && item_reg.region_moved;
    assign lens_s   = $signed({2'b0, lens_reg});
    assign stride_s = 18'(stride_reg);
    assign blo_s    = $signed({1'b0, blo_reg});
    assign bhi_s    = $signed({1'b0, bhi_reg});
    assign bpos_s   = $signed({1'b0, bpos_reg});
    assign v0       = lens_s + stride_s;
    assign v1       = (v0 < blo_s) ? blo_s : v0;
    assign v2       = (v1 > bhi_s) ? bhi_s : v1;
    assign end_hit  = ((stride_reg < 0) && (v2 == blo_s)) || ((stride_reg > 0) && (v2 == bhi_s));
    assign v_clamped = v2[17] ? 17'd0
                     : (v2 > $signed({1'b0, afs_pkg::FOCUS_LIMIT})) ? afs_pkg::FOCUS_LIMIT
                     : v2[16:0];
    assign brk_raw  = lens_s - stride_s;
    assign brk_val  = brk_raw[17] ? 17'd0
                    : (brk_raw > $signed({1'b0, afs_pkg::POS_TOP})) ? afs_pkg::POS_TOP
                    : brk_raw[16:0];
    assign worse    = item_reg.sharpness < bsharp_reg;
    assign lens_lt  = {1'b0, lens_reg} < bpos_reg;
    assign m3_blo   = worse ? (lens_lt ? {1'b0, lens_reg} : blo_reg)
                            : (lens_lt ? blo_reg : bpos_reg);
    assign m3_bhi   = worse ? (lens_lt ? bhi_reg : {1'b0, lens_reg})
                            : (lens_lt ? bpos_reg : bhi_reg);
    assign m3_width = $signed({1'b0, m3_bhi}) - $signed({1'b0, m3_blo});
    assign m3_go    = m3_width > afs_pkg::END_WIDTH;

    // Next lens position from the bracket.
    assign dl          = (blo_s > bpos_s) ? 17'(blo_s - bpos_s) : 17'(bpos_s - blo_s);
    assign dr          = (bhi_s > bpos_s) ? 17'(bhi_s - bpos_s) : 17'(bpos_s - bhi_s);
    assign divisor_eff = (cfg.step_divisor == 8'd0) ? 8'd1 : cfg.step_divisor;
    assign step        = (div_rsp.quotient[16:0] == 17'd0) ? 17'd1 : div_rsp.quotient[16:0];
    assign nf_down     = $signed({2'b0, bpos_reg}) - $signed({2'b0, step});
    assign nf_up       = $signed({2'b0, bpos_reg}) + $signed({2'b0, step});
    assign nf_calc     = dlgt_reg ? (nf_down[18] ? 17'd0 : nf_down[16:0])
                       : ((nf_up > $signed({2'b0, afs_pkg::FOCUS_LIMIT})) ? afs_pkg::FOCUS_LIMIT
                                                                           : nf_up[16:0]);

    // Settle timer.
    assign tdiff_s    = bpos_s - $signed({1'b0, nf_reg});
    assign tdiff      = tdiff_s[17] ? 17'(-tdiff_s) : tdiff_s[16:0];
    assign use_div    = (tdiff != 17'd0) && (cfg.focus_max > cfg.focus_min);
    assign minw       = (cfg.min_wait_ms == 16'd0) ? afs_pkg::DEFAULT_MIN_WAIT : cfg.min_wait_ms;
    assign ms_clamped = (ms_reg < {17'd0, minw}) ? {17'd0, minw} : ms_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            afs_pkg::ST_IDLE: begin
                if (accept) state_next = afs_pkg::ST_EXEC;
            end
            afs_pkg::ST_EXEC: begin
                unique case (item_reg.operation)
                    afs_pkg::OP_START:
                        state_next = start_sweep ? afs_pkg::ST_STRIDE : afs_pkg::ST_NF;
                    afs_pkg::OP_FRAME:
                        state_next = (!item_reg.format_changed && frame_go)
                                     ? afs_pkg::ST_ANALYZE : afs_pkg::ST_DONE;
                    default:
                        state_next = afs_pkg::ST_DONE;
                endcase
            end
            afs_pkg::ST_STRIDE: begin
                if (div_rsp.done) state_next = afs_pkg::ST_NF;
            end
            afs_pkg::ST_ANALYZE: begin
                if (restart_hit) begin
                    state_next = afs_pkg::ST_NF;
                end else if (mode_reg == afs_pkg::MODE_SWEEP
                             || mode_reg == afs_pkg::MODE_REVERSED) begin
                    if (sq_hi || (end_hit && mode_reg == afs_pkg::MODE_REVERSED))
                        state_next = afs_pkg::ST_NF;
                    else
                        state_next = afs_pkg::ST_TMUL;
                end else begin
                    state_next = m3_go ? afs_pkg::ST_NF : afs_pkg::ST_DONE;
                end
            end
            afs_pkg::ST_NF:      state_next = afs_pkg::ST_NF_WAIT;
            afs_pkg::ST_NF_WAIT: begin
                if (div_rsp.done) state_next = afs_pkg::ST_TMUL;
            end
            afs_pkg::ST_TMUL:    state_next = use_div ? afs_pkg::ST_TDIV : afs_pkg::ST_TMS;
            afs_pkg::ST_TDIV: begin
                if (div_rsp.done) state_next = afs_pkg::ST_TMS;
            end
            afs_pkg::ST_TMS:     state_next = afs_pkg::ST_TADD;
            afs_pkg::ST_TADD:    state_next = afs_pkg::ST_DONE;
            afs_pkg::ST_DONE: begin
                if (out_free) state_next = afs_pkg::ST_IDLE;
            end
            default:             state_next = afs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        item_next     = item_reg;
        mdata_next    = mdata_reg;
        mvalid_next   = mvalid_reg && !m_ready;
        mode_next     = mode_reg;
        blo_next      = blo_reg;
        bhi_next      = bhi_reg;
        bpos_next     = bpos_reg;
        bsharp_next   = bsharp_reg;
        lens_next     = lens_reg;
        stride_next   = stride_reg;
        frames_next   = frames_reg;
        hold_next     = hold_reg;
        deadline_next = deadline_reg;
        mv_next       = mv_reg;
        nf_next       = nf_reg;
        dlgt_next     = dlgt_reg;
        ms_next       = ms_reg;
        scaled_next   = scaled_reg;
        div_req.start    = 1'b0;
        div_req.dividend = {17'd0, range_mag};
        div_req.divisor  = afs_pkg::SWEEP_PARTS;

        unique case (state_reg)
            afs_pkg::ST_IDLE: begin
                if (accept) item_next = s_data;
            end
            afs_pkg::ST_EXEC: begin
                mv_next = 1'b0;
                nf_next = 17'd0;
                unique case (item_reg.operation)
                    afs_pkg::OP_START: begin
                        lens_next   = item_reg.focus_position;
                        frames_next = 4'd0;
                        blo_next    = {1'b0, cfg.focus_min};
                        bhi_next    = {1'b0, cfg.focus_max};
                        bsharp_next = item_reg.sharpness;
                        bpos_next   = {1'b0, item_reg.focus_position};
                        if (start_sweep) begin
                            mode_next     = afs_pkg::MODE_SWEEP;
                            div_req.start = 1'b1;
                        end else begin
                            mode_next   = afs_pkg::MODE_BRACKET;
                            stride_next = '0;
                        end
                    end
                    afs_pkg::OP_FRAME: begin
                        if (item_reg.format_changed) begin
                            mode_next = afs_pkg::MODE_ENDED;
                        end else begin
                            lens_next = item_reg.focus_position;
                            if (mode_reg != afs_pkg::MODE_ENDED) hold_next = hold_dec;
                        end
                    end
                    afs_pkg::OP_STOP: mode_next = afs_pkg::MODE_ENDED;
                    default: ;
                endcase
            end
            afs_pkg::ST_STRIDE: begin
                if (div_rsp.done) stride_next = (left_gap > right_gap) ? -stride_q : stride_q;
            end
            afs_pkg::ST_ANALYZE: begin
                frames_next = frames_inc;
                if (restart_hit) begin
                    blo_next    = {1'b0, cfg.focus_min};
                    bhi_next    = {1'b0, cfg.focus_max};
                    bsharp_next = item_reg.sharpness;
                    bpos_next   = {1'b0, lens_reg};
                end else if (mode_reg == afs_pkg::MODE_SWEEP
                             || mode_reg == afs_pkg::MODE_REVERSED) begin
                    if (sq_hi) begin
                        mode_next = afs_pkg::MODE_BRACKET;
                        if (stride_reg > 0) blo_next = brk_val;
                        else bhi_next = brk_val;
                        bpos_next   = {1'b0, lens_reg};
                        bsharp_next = item_reg.sharpness;
                    end else if (end_hit && mode_reg == afs_pkg::MODE_SWEEP) begin
                        mode_next   = afs_pkg::MODE_REVERSED;
                        stride_next = -stride_reg;
                        mv_next     = 1'b1;
                        nf_next     = bpos_reg;
                    end else if (end_hit) begin
                        mode_next   = afs_pkg::MODE_BRACKET;
                        bpos_next   = {1'b0, lens_reg};
                        bsharp_next = item_reg.sharpness;
                    end else begin
                        mv_next = 1'b1;
                        nf_next = v_clamped;
                    end
                end else begin
                    blo_next = m3_blo;
                    bhi_next = m3_bhi;
                    if (!worse) begin
                        bpos_next   = {1'b0, lens_reg};
                        bsharp_next = item_reg.sharpness;
                    end
                    if (!m3_go) mode_next = afs_pkg::MODE_ENDED;
                end
            end
            afs_pkg::ST_NF: begin
                dlgt_next        = dl > dr;
                div_req.start    = 1'b1;
                div_req.dividend = {16'd0, (dl > dr) ? dl : dr};
                div_req.divisor  = {8'd0, divisor_eff};
            end
            afs_pkg::ST_NF_WAIT: begin
                if (div_rsp.done) begin
                    mv_next = 1'b1;
                    nf_next = nf_calc;
                end
            end
            afs_pkg::ST_TMUL: begin
                ms_next = '0;
                if (use_div) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = tdiff * cfg.max_wait_ms;
                    div_req.divisor  = cfg.focus_max - cfg.focus_min;
                end
            end
            afs_pkg::ST_TDIV: begin
                if (div_rsp.done) ms_next = div_rsp.quotient;
            end
            afs_pkg::ST_TMS: begin
                scaled_next = ms_clamped * afs_pkg::US_PER_MS;
            end
            afs_pkg::ST_TADD: begin
                deadline_next = item_reg.time_us + {21'd0, scaled_reg};
                hold_next     = afs_pkg::HOLDOFF_FRAMES;
            end
            afs_pkg::ST_DONE: begin
                if (out_free) begin
                    mvalid_next              = 1'b1;
                    mdata_next.move          = mv_reg;
                    mdata_next.target_focus  = mv_reg ? nf_reg : 17'd0;
                    mdata_next.search_mode   = mode_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= afs_pkg::ST_IDLE;
            mvalid_reg   <= 1'b0;
            mode_reg     <= afs_pkg::MODE_ENDED;
            blo_reg      <= '0;
            bhi_reg      <= '0;
            bpos_reg     <= '0;
            bsharp_reg   <= '0;
            lens_reg     <= '0;
            stride_reg   <= '0;
            frames_reg   <= '0;
            hold_reg     <= '0;
            deadline_reg <= '0;
        end else begin
            state_reg    <= state_next;
            mvalid_reg   <= mvalid_next;
            mode_reg     <= mode_next;
            blo_reg      <= blo_next;
            bhi_reg      <= bhi_next;
            bpos_reg     <= bpos_next;
            bsharp_reg   <= bsharp_next;
            lens_reg     <= lens_next;
            stride_reg   <= stride_next;
            frames_reg   <= frames_next;
            hold_reg     <= hold_next;
            deadline_reg <= deadline_next;
        end
        item_reg   <= item_next;
        mdata_reg  <= mdata_next;
        mv_reg     <= mv_next;
        nf_reg     <= nf_next;
        dlgt_reg   <= dlgt_next;
        ms_reg     <= ms_next;
        scaled_reg <= scaled_next;
    end

    a_no_move_zero_focus: assert property (@(posedge aclk) disable iff (!aresetn)
        (mvalid_reg && !mdata_reg.move) |-> (mdata_reg.target_focus == 17'd0))
        else $error("Result beat without a move carries a non-zero focus.");

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("Divider started while still busy.");

    a_div_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == afs_pkg::ST_STRIDE || state_reg == afs_pkg::ST_NF_WAIT
                          || state_reg == afs_pkg::ST_TDIV))
        else $error("Divider finished while the sequencer was not waiting for it.");

    a_holdoff_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_reg != 3'sb100)
        else $error("Holdoff counter fell below its floor.");

endmodule
